>>> src/flsa_pkg.sv
// Shared types and codes for the free-list slot allocator.
// Used by the channel interfaces, the controller, the datapath and the checker.
// No dependencies.
package flsa_pkg;

  // Width of a slot number on the channels; slot 0 means "no slot"
  localparam int SLOT_W = 9;

  typedef logic [SLOT_W-1:0] slot_t;

  // Request codes on the input channel
  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  // Result codes on the output channel
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_BAD_SLOT  = 2'd2
  } status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // input beat taken this cycle
    logic finish;  // complete a list pop with the link read last cycle
    logic drain;   // output beat taken this cycle
  } flsa_ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic needs_pop;  // current input is an allocate served from the free list
    logic out_full;   // output register holds a result
  } flsa_sts_t;

endpackage

>>> src/flsa_if.sv
// Valid/ready channel interfaces for the slot allocator request and result.
// Depends on flsa_pkg.
interface flsa_in_if;
  logic                valid;
  logic                ready;
  logic                cmd;
  flsa_pkg::slot_t     freed_slot;

  modport source (output valid, output cmd, output freed_slot, input ready);
  modport sink   (input valid, input cmd, input freed_slot, output ready);
endinterface

interface flsa_out_if;
  logic                valid;
  logic                ready;
  flsa_pkg::slot_t     granted_slot;
  logic [1:0]          status;

  modport source (output valid, output granted_slot, output status, input ready);
  modport sink   (input valid, input granted_slot, input status, output ready);
endinterface

>>> src/flsa_ctrl.sv
// Controller of the slot allocator: handshake and the list pop through the S_POP state.
// Depends on flsa_pkg.
module flsa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                out_ready,
  input  flsa_pkg::flsa_sts_t sts,
  output flsa_pkg::flsa_ctl_t ctl
);

  typedef enum logic {
    S_IDLE,
    S_POP
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Take a beat only when idle and the output register is free or draining
  assign in_ready = (state_r == S_IDLE) && (!sts.out_full || out_ready);

  always_comb begin
    ctl.load   = in_valid && in_ready;
    ctl.finish = (state_r == S_POP);
    ctl.drain  = sts.out_full && out_ready;
  end

  // Advance to the pop state while the link read is in flight
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (ctl.load && sts.needs_pop) state_nxt = S_POP;
      end
      S_POP: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> src/flsa_dp.sv
// Datapath of the slot allocator: link memory, free-list head, bump pointer
// and the result register. Depends on flsa_pkg.
module flsa_dp #(
  parameter int SLOTS = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  flsa_pkg::flsa_ctl_t  ctl,
  output flsa_pkg::flsa_sts_t  sts,
  input  logic                 in_cmd,
  input  flsa_pkg::slot_t      in_freed_slot,
  output logic                 out_valid,
  output flsa_pkg::slot_t      out_granted_slot,
  output logic [1:0]           out_status
);

  localparam int SW      = flsa_pkg::SLOT_W;
  localparam int MAX_NUM = (1 << SW) - 1;
  // Only slots that fit a channel field can ever be linked
  localparam int DEPTH   = (SLOTS < MAX_NUM) ? SLOTS : MAX_NUM;
  localparam int AW      = $clog2(DEPTH);
  // Bump pointer must reach SLOTS + 1 to mark exhaustion
  localparam int NF_W    = $clog2(SLOTS + 2);
  localparam int CW      = (NF_W > SW) ? NF_W : SW;
  localparam logic [CW-1:0] LIMIT = CW'(SLOTS);

  flsa_pkg::slot_t     link_mem [DEPTH];
  flsa_pkg::slot_t     rd_link_r;
  flsa_pkg::slot_t     head_r;
  logic [NF_W-1:0]     fresh_r;
  logic                out_valid_r;
  flsa_pkg::slot_t     out_slot_r;
  flsa_pkg::status_t   out_stat_r;

  logic                list_ok;
  logic                slot_ok;
  logic                fresh_ok;
  logic                is_free;
  flsa_pkg::slot_t     head_m1;
  flsa_pkg::slot_t     slot_m1;
  logic                wr_en;
  logic                rd_en;

  // Range checks on the head, the freed slot and the bump pointer
  assign list_ok  = (head_r != '0) && (CW'(head_r) <= LIMIT);
  assign slot_ok  = (in_freed_slot != '0) && (CW'(in_freed_slot) <= LIMIT);
  assign fresh_ok = (CW'(fresh_r) <= LIMIT);
  assign is_free  = (in_cmd == flsa_pkg::CMD_FREE);
  assign head_m1  = head_r - SW'(1);
  assign slot_m1  = in_freed_slot - SW'(1);

  assign wr_en = ctl.load && is_free && slot_ok;
  assign rd_en = ctl.load && !is_free && list_ok;

  always_comb begin
    sts.needs_pop = !is_free && list_ok;
    sts.out_full  = out_valid_r;
  end

  // Link memory: push writes the old head, pop reads the head's link
  always_ff @(posedge clk) begin
    if (wr_en) link_mem[slot_m1[AW-1:0]] <= head_r;
    if (rd_en) rd_link_r <= link_mem[head_m1[AW-1:0]];
  end

  // List head and bump pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      fresh_r <= NF_W'(1);
    end else begin
      if (wr_en) begin
        head_r <= in_freed_slot;
      end else if (ctl.finish) begin
        head_r <= rd_link_r;
      end
      if (ctl.load && !is_free && !list_ok && fresh_ok) begin
        fresh_r <= fresh_r + NF_W'(1);
      end
    end
  end

  // Result valid: raise when a result is ready, else drop on a taken beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.finish || (ctl.load && !rd_en)) begin
        out_valid_r <= 1'b1;
      end else if (ctl.drain) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      if (is_free) begin
        out_slot_r <= '0;
        out_stat_r <= slot_ok ? flsa_pkg::ST_OK : flsa_pkg::ST_BAD_SLOT;
      end else if (list_ok) begin
        out_slot_r <= head_r;
        out_stat_r <= flsa_pkg::ST_OK;
      end else if (fresh_ok) begin
        out_slot_r <= SW'(fresh_r);
        out_stat_r <= flsa_pkg::ST_OK;
      end else begin
        out_slot_r <= '0;
        out_stat_r <= flsa_pkg::ST_EXHAUSTED;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_granted_slot = out_slot_r;
  assign out_status       = out_stat_r;

endmodule

>>> src/free_list_slot_allocator_unit.sv
// Fixed-size slot allocator, SLOTS slots numbered from 1 (0 means no slot).
// An allocate pops the head of a free list whose links live in a link memory,
// or takes the next never-used slot from a bump pointer when the list is
// empty; a free pushes the slot onto the list. Exhaustion and a free of slot 0
// or of a slot above SLOTS are reported in status and change nothing. A free,
// a bump-pointer allocate and every error give their result in the cycle after
// the input beat; an allocate from the free list first goes through the
// registered read of the head's link from the single link memory. One
// request is in flight at a time, and a new beat is taken while the previous
// result is being taken on the output. The link memory needs no clearing
// after reset. Depends on flsa_pkg, flsa_if, flsa_ctrl and flsa_dp.
module free_list_slot_allocator_unit #(
  parameter int SLOTS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  flsa_in_if.sink     in_ch,
  flsa_out_if.source  out_ch
);

  flsa_pkg::flsa_ctl_t ctl;
  flsa_pkg::flsa_sts_t sts;

  flsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  flsa_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .sts              (sts),
    .in_cmd           (in_ch.cmd),
    .in_freed_slot    (in_ch.freed_slot),
    .out_valid        (out_ch.valid),
    .out_granted_slot (out_ch.granted_slot),
    .out_status       (out_ch.status)
  );

endmodule

>>> src/flsa_chk.sv
// Port-level checker for the slot allocator, bound to the top level.
// Depends on flsa_pkg and free_list_slot_allocator_unit.
module flsa_chk (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            in_cmd,
  input flsa_pkg::slot_t in_freed_slot,
  input logic            out_valid,
  input logic            out_ready,
  input flsa_pkg::slot_t out_granted_slot,
  input logic [1:0]      out_status
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_granted_slot)
      && $stable(out_status))
    else $error("stalled result beat changed");

  // Take no request while a result is stalled
  a_no_accept_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken while result stalled");

  // A failed request grants no slot
  a_fail_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != 2'(flsa_pkg::ST_OK)) |-> out_granted_slot == '0)
    else $error("slot granted with error status");

  // A free of slot 0 is flagged in the next cycle
  a_free_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_cmd == flsa_pkg::CMD_FREE) && (in_freed_slot == '0)
      |=> out_valid && (out_status == 2'(flsa_pkg::ST_BAD_SLOT))
        && (out_granted_slot == '0))
    else $error("free of slot 0 not flagged");

endmodule

bind free_list_slot_allocator_unit flsa_chk u_flsa_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_cmd           (in_ch.cmd),
  .in_freed_slot    (in_ch.freed_slot),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_granted_slot (out_ch.granted_slot),
  .out_status       (out_ch.status)
);

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for free_list_slot_allocator_unit: directed and random requests
// checked beat by beat against a cycle-free model of the free list and bump pointer.
// Depends on flsa_pkg, flsa_if and the allocator RTL.
module tb_top;

  localparam int SLOT_COUNT  = 256;
  localparam int STUCK_LIMIT = 2000;
  localparam int LONG_HOLD   = 300;

  typedef struct {
    flsa_pkg::slot_t   granted;
    flsa_pkg::status_t status;
  } slot_result_t;

  // Tracks the allocator state and the results it owes, oldest first
  class slot_ledger;
    flsa_pkg::slot_t link_of [1:SLOT_COUNT];
    flsa_pkg::slot_t head;
    flsa_pkg::slot_t fresh;
    slot_result_t    owed[$];
    int              failures;

    function new();
      foreach (link_of[i]) link_of[i] = '0;
      head     = '0;
      fresh    = 9'd1;
      failures = 0;
    endfunction

    // Apply one accepted request and queue its result; return the granted slot
    function flsa_pkg::slot_t take_request(flsa_pkg::cmd_t c, flsa_pkg::slot_t s);
      slot_result_t r;
      r.granted = '0;
      r.status  = flsa_pkg::ST_OK;
      if (c == flsa_pkg::CMD_ALLOC) begin
        if (head != 0) begin
          r.granted = head;
          head      = link_of[head];
        end else if (fresh <= SLOT_COUNT) begin
          r.granted = fresh;
          fresh     = fresh + 1'b1;
        end else begin
          r.status = flsa_pkg::ST_EXHAUSTED;
        end
      end else if (s >= 1 && s <= SLOT_COUNT) begin
        link_of[s] = head;
        head       = s;
      end else begin
        r.status = flsa_pkg::ST_BAD_SLOT;
      end
      owed.push_back(r);
      return r.granted;
    endfunction

    // Compare one result beat with the oldest owed result
    function void check_result(flsa_pkg::slot_t g, logic [1:0] st);
      slot_result_t want;
      if (owed.size() == 0) begin
        $display("%0t: result with nothing owed: expected none, got slot %0d status %0d",
                 $time, g, st);
        failures++;
        return;
      end
      want = owed.pop_front();
      if (g !== want.granted) begin
        $display("%0t: granted_slot mismatch: expected %0d, got %0d", $time, want.granted, g);
        failures++;
      end
      if (st !== want.status) begin
        $display("%0t: status mismatch: expected %0d, got %0d", $time, want.status, st);
        failures++;
      end
    endfunction

    function int outstanding();
      return owed.size();
    endfunction
  endclass

  logic            clk;
  logic            rst_n;
  int              stuck_cycles = 0;
  bit              calm;
  bit              hold_off_req;
  flsa_pkg::slot_t held[$];
  slot_ledger      ledger = new();

  flsa_in_if  in_ch ();
  flsa_out_if out_ch ();

  free_list_slot_allocator_unit #(.SLOTS(SLOT_COUNT)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Offer one request and hold it until the block takes the beat
  task automatic send_request(input flsa_pkg::cmd_t c, input flsa_pkg::slot_t s);
    flsa_pkg::slot_t got;
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= c;
    in_ch.freed_slot <= s;
    do @(posedge clk); while (!in_ch.ready);
    got = ledger.take_request(c, s);
    if (c == flsa_pkg::CMD_ALLOC && got != 0) held.push_back(got);
  endtask

  // Drop valid for a burst of cycles
  task automatic pause_sender(input int n);
    in_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Random requests: allocations, frees of held slots, and stray frees
  task automatic run_requests(input int count, input int alloc_pct, input int free_pct);
    int unsigned     r;
    int              k;
    flsa_pkg::slot_t s;
    for (int i = 0; i < count; i++) begin
      if (!calm && $urandom_range(0, 7) == 0) pause_sender($urandom_range(1, 15));
      r = $urandom_range(0, 99);
      if (r < alloc_pct) begin
        send_request(flsa_pkg::CMD_ALLOC, flsa_pkg::slot_t'($urandom_range(0, 511)));
      end else if (r < alloc_pct + free_pct && held.size() > 0) begin
        k = $urandom_range(0, held.size() - 1);
        s = held[k];
        held.delete(k);
        send_request(flsa_pkg::CMD_FREE, s);
      end else if ($urandom_range(0, 1) == 1) begin
        // in range, possibly a double free or a slot never handed out
        send_request(flsa_pkg::CMD_FREE, flsa_pkg::slot_t'($urandom_range(1, SLOT_COUNT)));
      end else if ($urandom_range(0, 3) == 0) begin
        send_request(flsa_pkg::CMD_FREE, '0);
      end else begin
        send_request(flsa_pkg::CMD_FREE,
                     flsa_pkg::slot_t'($urandom_range(SLOT_COUNT + 1, 511)));
      end
    end
  endtask

  // Result side: check every beat, stall in random bursts, honor the long hold-off
  initial begin
    int stall_left;
    int hold_left;
    bit hold_done;
    stall_left = 0;
    hold_left  = 0;
    hold_done  = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        ledger.check_result(out_ch.granted_slot, out_ch.status);
      if (hold_off_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 14);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Count cycles with no beat on either side; bail out when stuck
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles == STUCK_LIMIT) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  // Main sequence
  initial begin
    calm              = 1'b0;
    hold_off_req      = 1'b0;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.cmd        <= flsa_pkg::CMD_ALLOC;
    in_ch.freed_slot <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: fresh slots, stray frees, list pops, ignored slot field
    send_request(flsa_pkg::CMD_ALLOC, '0);
    send_request(flsa_pkg::CMD_ALLOC, 9'd511);
    send_request(flsa_pkg::CMD_ALLOC, '0);
    send_request(flsa_pkg::CMD_FREE, '0);
    send_request(flsa_pkg::CMD_FREE, 9'd257);
    send_request(flsa_pkg::CMD_FREE, 9'd511);
    send_request(flsa_pkg::CMD_FREE, 9'd256);
    send_request(flsa_pkg::CMD_ALLOC, '0);
    send_request(flsa_pkg::CMD_FREE, 9'd2);
    send_request(flsa_pkg::CMD_FREE, 9'd1);
    send_request(flsa_pkg::CMD_ALLOC, '0);
    send_request(flsa_pkg::CMD_ALLOC, '0);
    send_request(flsa_pkg::CMD_ALLOC, '0);
    send_request(flsa_pkg::CMD_FREE, 9'd1);
    send_request(flsa_pkg::CMD_ALLOC, 9'd256);
    send_request(flsa_pkg::CMD_ALLOC, 9'd511);

    // Long output hold-off while requests keep coming
    hold_off_req = 1'b1;

    // Allocation-heavy: run the bump pointer dry and hit exhaustion
    run_requests(320, 95, 3);
    // Balanced churn over a deep free list
    run_requests(220, 50, 40);
    calm = 1'b1;
    run_requests(80, 50, 40);

    // Double free last: it leaves a self-linked slot that the list never leaves
    send_request(flsa_pkg::CMD_FREE, 9'd3);
    send_request(flsa_pkg::CMD_FREE, 9'd3);
    send_request(flsa_pkg::CMD_ALLOC, '0);
    send_request(flsa_pkg::CMD_ALLOC, '0);
    send_request(flsa_pkg::CMD_ALLOC, '0);
    in_ch.valid <= 1'b0;

    // Drain owed results, then let any stray beat show up
    while (ledger.outstanding() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (ledger.failures == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
